// ===== design/wvae_pkg.sv =====
package wvae_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;

  localparam int DATA_W = 32;
  localparam int RATE_W = 10;
  localparam logic [RATE_W-1:0] RATE_RESET = 10'd50;

  localparam int MAG_W     = 44;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = MAG_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CH_POS_S = 2'b00,
    CH_POS_D = 2'b01,
    CH_VEL_S = 2'b10,
    CH_VEL_D = 2'b11
  } chan_t;

  typedef struct packed {
    logic  load_pos;
    logic  sub;
    logic  mul;
    logic  div;
    logic  fin;
    logic  vpush;
    logic  load_out;
    chan_t chan;
  } cmd_t;

  typedef struct packed {
    logic pos_ok;
    logic vel_ok;
  } status_t;

endpackage

// ===== design/wvae_ctrl.sv =====
module wvae_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wvae_pkg::status_t status,
  output wvae_pkg::cmd_t    cmd
);
  import wvae_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SUB   = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_FIN   = 7'b0010000,
    ST_VPUSH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state, state_next;
  chan_t               chan, chan_next;
  logic [STEP_W-1:0]   step, step_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    chan_next  = chan;
    step_next  = step;
    cmd        = '0;
    cmd.chan   = chan;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_pos = 1'b1;
          chan_next    = CH_POS_S;
          state_next   = ST_SUB;
        end
      end
      ST_SUB: begin
        if ((chan inside {CH_POS_S, CH_POS_D} && !status.pos_ok) ||
            (chan inside {CH_VEL_S, CH_VEL_D} && !status.vel_ok)) begin
          state_next = ST_DONE;
        end else begin
          cmd.sub    = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        case (chan)
          CH_POS_S: begin
            chan_next  = CH_POS_D;
            state_next = ST_SUB;
          end
          CH_POS_D: state_next = ST_VPUSH;
          CH_VEL_S: begin
            chan_next  = CH_VEL_D;
            state_next = ST_SUB;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_VPUSH: begin
        cmd.vpush  = 1'b1;
        chan_next  = CH_VEL_S;
        state_next = ST_SUB;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= CH_POS_S;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      step  <= step_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SUB && chan == CH_POS_S))
    else $error("item did not start on longitudinal position");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |=> (state == ST_DIV && step == '0))
    else $error("division did not start at first digit");

  a_vel_push: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && chan == CH_POS_D) |=> (state == ST_VPUSH))
    else $error("velocity not pushed after both axes");

endmodule

// ===== design/wvae_dp.sv =====
module wvae_dp #(
  parameter int HISTORY_DEPTH = wvae_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wvae_pkg::RATE_W-1:0]         cfg_data,
  input  logic signed [wvae_pkg::DATA_W-1:0]  pos_s,
  input  logic signed [wvae_pkg::DATA_W-1:0]  pos_d,
  input  wvae_pkg::cmd_t                      cmd,
  output wvae_pkg::status_t                   status,
  output logic signed [wvae_pkg::DATA_W-1:0]  vel_s,
  output logic signed [wvae_pkg::DATA_W-1:0]  vel_d,
  output logic signed [wvae_pkg::DATA_W-1:0]  acc_s,
  output logic signed [wvae_pkg::DATA_W-1:0]  acc_d,
  output logic                                vel_valid,
  output logic                                acc_valid
);
  import wvae_pkg::*;

  localparam int IW  = $clog2(HISTORY_DEPTH);
  localparam int FW  = $clog2(HISTORY_DEPTH + 1);
  localparam int DVW = $clog2(HISTORY_DEPTH);
  localparam logic [MAG_W-1:0]  POS_LIM = MAG_W'(64'h7FFF_FFFF);
  localparam logic [MAG_W-1:0]  NEG_LIM = MAG_W'(64'h8000_0000);
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [RATE_W-1:0]         rate;
  logic [FW-1:0]             pos_fill, vel_fill;
  logic                      pos_full, vel_full;
  logic [DATA_W-1:0]         pos_win [2][HISTORY_DEPTH];
  logic [DATA_W-1:0]         vel_win [2][HISTORY_DEPTH];
  logic [DATA_W-1:0]         in_pos  [2];
  logic [DATA_W-1:0]         cur_new [2][2];
  logic [DATA_W-1:0]         cur_old [2][2];
  logic [DATA_W-1:0]         res     [2][2];
  logic [DATA_W-1:0]         sel_new, sel_old;
  logic [FW-1:0]             sel_fill;
  logic [DATA_W:0]           diff;
  logic [DATA_W:0]           abs_diff;
  logic [DATA_W+RATE_W:0]    prod;
  logic                      neg;
  logic [MAG_W-1:0]          quo, quo_next;
  logic [DVW-1:0]            rem, rem_next, dvs;
  logic [DATA_W-1:0]         sat_val;

  assign in_pos[0] = pos_s;
  assign in_pos[1] = pos_d;
  assign pos_full  = (pos_fill == FW'(HISTORY_DEPTH));
  assign vel_full  = (vel_fill == FW'(HISTORY_DEPTH));
  assign status.pos_ok = (pos_fill > FW'(1));
  assign status.vel_ok = (vel_fill > FW'(1));

  assign sel_new  = cur_new[cmd.chan[1]][cmd.chan[0]];
  assign sel_old  = cur_old[cmd.chan[1]][cmd.chan[0]];
  assign sel_fill = cmd.chan[1] ? vel_fill : pos_fill;
  assign abs_diff = diff[DATA_W] ? (~diff + 1'b1) : diff;
  assign prod     = abs_diff * rate;

  always_comb begin
    logic [DVW:0]     t;
    logic [MAG_W-1:0] q;
    logic [DVW-1:0]   r;
    q = quo;
    r = rem;
    for (int k = 0; k < DIV_BITS; k++) begin
      t = {r, q[MAG_W-1]};
      q = {q[MAG_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t    = t - {1'b0, dvs};
        q[0] = 1'b1;
      end
      r = t[DVW-1:0];
    end
    quo_next = q;
    rem_next = r;
  end

  always_comb begin
    if (neg) begin
      sat_val = (quo > NEG_LIM) ? SAT_MIN : (~quo[DATA_W-1:0] + 1'b1);
    end else begin
      sat_val = (quo > POS_LIM) ? SAT_MAX : quo[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate     <= RATE_RESET;
      pos_fill <= '0;
      vel_fill <= '0;
    end else begin
      if (cfg_we) begin
        rate <= cfg_data;
      end
      if (cmd.load_pos && !pos_full) begin
        pos_fill <= pos_fill + FW'(1);
      end
      if (cmd.vpush && !vel_full) begin
        vel_fill <= vel_fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      for (int a = 0; a < 2; a++) begin
        if (pos_full) begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            pos_win[a][i] <= pos_win[a][i+1];
          end
          pos_win[a][HISTORY_DEPTH-1] <= in_pos[a];
        end else begin
          pos_win[a][pos_fill[IW-1:0]] <= in_pos[a];
        end
        cur_new[0][a] <= in_pos[a];
        cur_old[0][a] <= pos_full ? pos_win[a][1] : pos_win[a][0];
      end
    end
    if (cmd.vpush) begin
      for (int a = 0; a < 2; a++) begin
        if (vel_full) begin
          for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            vel_win[a][i] <= vel_win[a][i+1];
          end
          vel_win[a][HISTORY_DEPTH-1] <= res[0][a];
        end else begin
          vel_win[a][vel_fill[IW-1:0]] <= res[0][a];
        end
        cur_new[1][a] <= res[0][a];
        cur_old[1][a] <= vel_full ? vel_win[a][1] : vel_win[a][0];
      end
    end
    if (cmd.sub) begin
      diff <= {sel_new[DATA_W-1], sel_new} - {sel_old[DATA_W-1], sel_old};
      dvs  <= DVW'(sel_fill - FW'(1));
    end
    if (cmd.mul) begin
      quo <= MAG_W'(prod);
      rem <= '0;
      neg <= diff[DATA_W];
    end
    if (cmd.div) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (cmd.fin) begin
      res[cmd.chan[1]][cmd.chan[0]] <= sat_val;
    end
    if (cmd.load_out) begin
      vel_s     <= status.pos_ok ? res[0][0] : '0;
      vel_d     <= status.pos_ok ? res[0][1] : '0;
      acc_s     <= status.vel_ok ? res[1][0] : '0;
      acc_d     <= status.vel_ok ? res[1][1] : '0;
      vel_valid <= status.pos_ok;
      acc_valid <= status.vel_ok;
    end
  end

endmodule

// ===== design/windowed_velocity_accel_estimator.sv =====
// The result carries no estimate while the position window holds one sample, both
// velocities once it holds two, and both accelerations too once the velocity window
// holds two. No new item is accepted until the result is loaded; up to four serial
// divisions of 11 radix-16 steps each run one after another through the one divider.
// Reset: synchronous, active high; clears both window fill counts and the result
// valid flag, and sets the rate register to 50. Window contents are not cleared.
module windowed_velocity_accel_estimator #(
  parameter int HISTORY_DEPTH = wvae_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wvae_pkg::RATE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [wvae_pkg::DATA_W-1:0]  pos_s,
  input  logic signed [wvae_pkg::DATA_W-1:0]  pos_d,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wvae_pkg::DATA_W-1:0]  vel_s,
  output logic signed [wvae_pkg::DATA_W-1:0]  vel_d,
  output logic signed [wvae_pkg::DATA_W-1:0]  acc_s,
  output logic signed [wvae_pkg::DATA_W-1:0]  acc_d,
  output logic                                vel_valid,
  output logic                                acc_valid
);
  import wvae_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  wvae_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wvae_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pos_s     (pos_s),
    .pos_d     (pos_d),
    .cmd       (cmd),
    .status    (status),
    .vel_s     (vel_s),
    .vel_d     (vel_d),
    .acc_s     (acc_s),
    .acc_d     (acc_d),
    .vel_valid (vel_valid),
    .acc_valid (acc_valid)
  );

endmodule

// ===== sim/tb_windowed_velocity_accel_estimator.sv =====
module tb_windowed_velocity_accel_estimator;
  import wvae_pkg::*;

  localparam int HD = HISTORY_DEPTH_DEF;
  localparam int EXP_DEPTH = 16;
  localparam logic signed [DATA_W-1:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MINV = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] vs;
    logic signed [DATA_W-1:0] vd;
    logic signed [DATA_W-1:0] as;
    logic signed [DATA_W-1:0] ad;
    logic                     vv;
    logic                     av;
  } est_t;

  typedef struct {
    bit                       is_cfg;
    logic [RATE_W-1:0]        rate;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] d;
    bit                       typed;
    est_t                     want;
  } row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [RATE_W-1:0]        cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] pos_s;
  logic signed [DATA_W-1:0] pos_d;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] vel_s;
  logic signed [DATA_W-1:0] vel_d;
  logic signed [DATA_W-1:0] acc_s;
  logic signed [DATA_W-1:0] acc_d;
  logic                     vel_valid;
  logic                     acc_valid;

  windowed_velocity_accel_estimator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pos_s     (pos_s),
    .pos_d     (pos_d),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vel_s     (vel_s),
    .vel_d     (vel_d),
    .acc_s     (acc_s),
    .acc_d     (acc_d),
    .vel_valid (vel_valid),
    .acc_valid (acc_valid)
  );

  // estimator state: position and velocity histories, oldest first
  logic signed [DATA_W-1:0] hist [0:3][HD];
  int                       pos_fill;
  int                       vel_fill;
  logic [RATE_W-1:0]        rate_hz;

  est_t                     expected_est [EXP_DEPTH];
  int                       exp_head;
  int                       exp_tail;
  int                       exp_count;
  int                       mismatches;
  int                       results_seen;
  int                       burst_left;
  logic signed [DATA_W-1:0] traj [2];
  logic signed [DATA_W-1:0] step [2];

  row_t dir_rows [24] = '{
    '{1'b0, 10'd0, 0,    0,    1'b1, '{0,    0,    0,    0,    1'b0, 1'b0}},
    '{1'b0, 10'd0, MAXV, MINV, 1'b1, '{MAXV, MINV, 0,    0,    1'b1, 1'b0}},
    '{1'b0, 10'd0, MINV, MAXV, 1'b1, '{MINV, MAXV, MINV, MAXV, 1'b1, 1'b1}},
    '{1'b0, 10'd0, 1,    -1,   1'b0, '0},
    '{1'b0, 10'd0, 7,    -7,   1'b0, '0},
    '{1'b0, 10'd0, -3,   3,    1'b0, '0},
    '{1'b0, 10'd0, 100,  -100, 1'b0, '0},
    '{1'b0, 10'd0, 0,    0,    1'b0, '0},
    '{1'b1, 10'd0, 0,    0,    1'b0, '0},
    '{1'b0, 10'd0, 12345, -999, 1'b1, '{0,   0,    0,    0,    1'b1, 1'b1}},
    '{1'b0, 10'd0, MAXV, MINV, 1'b1, '{0,    0,    0,    0,    1'b1, 1'b1}},
    '{1'b1, 10'd1023, 0, 0,    1'b0, '0},
    '{1'b0, 10'd0, MINV, MAXV, 1'b0, '0},
    '{1'b0, 10'd0, MAXV, MINV, 1'b0, '0},
    '{1'b0, 10'd0, -1,   -1,   1'b0, '0},
    '{1'b0, 10'd0, 5,    -5,   1'b0, '0},
    '{1'b1, 10'd1, 0,    0,    1'b0, '0},
    '{1'b0, 10'd0, 1024, -1024, 1'b0, '0},
    '{1'b0, 10'd0, 2048, -2048, 1'b0, '0},
    '{1'b0, 10'd0, 3072, -3072, 1'b0, '0},
    '{1'b0, 10'd0, 4096, -4096, 1'b0, '0},
    '{1'b0, 10'd0, 5120, -5120, 1'b0, '0},
    '{1'b0, 10'd0, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, '0},
    '{1'b0, 10'd0, -1,   0,    1'b0, '0}
  };

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [DATA_W-1:0] window_slope(
    input logic signed [DATA_W-1:0] newest,
    input logic signed [DATA_W-1:0] oldest,
    input int span
  );
    longint diff;
    longint num;
    longint q;
    diff = longint'(newest) - longint'(oldest);
    num  = diff * longint'(rate_hz);
    q    = num / longint'(span);
    if (q > longint'(MAXV)) return MAXV;
    if (q < longint'(MINV)) return MINV;
    return q[DATA_W-1:0];
  endfunction

  function automatic void push_hist(input chan_t ch, input int fill,
                                    input logic signed [DATA_W-1:0] v);
    if (fill >= HD) begin
      for (int i = 0; i < HD - 1; i++) hist[ch][i] = hist[ch][i+1];
      hist[ch][HD-1] = v;
    end else begin
      hist[ch][fill] = v;
    end
  endfunction

  function automatic est_t predict_estimate(input logic signed [DATA_W-1:0] s,
                                            input logic signed [DATA_W-1:0] d);
    est_t e;
    e = '0;
    push_hist(CH_POS_S, pos_fill, s);
    push_hist(CH_POS_D, pos_fill, d);
    pos_fill = (pos_fill < HD) ? pos_fill + 1 : HD;
    if (pos_fill > 1) begin
      e.vs = window_slope(hist[CH_POS_S][pos_fill-1], hist[CH_POS_S][0], pos_fill - 1);
      e.vd = window_slope(hist[CH_POS_D][pos_fill-1], hist[CH_POS_D][0], pos_fill - 1);
      e.vv = 1'b1;
      push_hist(CH_VEL_S, vel_fill, e.vs);
      push_hist(CH_VEL_D, vel_fill, e.vd);
      vel_fill = (vel_fill < HD) ? vel_fill + 1 : HD;
    end
    if (vel_fill > 1) begin
      e.as = window_slope(hist[CH_VEL_S][vel_fill-1], hist[CH_VEL_S][0], vel_fill - 1);
      e.ad = window_slope(hist[CH_VEL_D][vel_fill-1], hist[CH_VEL_D][0], vel_fill - 1);
      e.av = 1'b1;
    end
    return e;
  endfunction

  // mostly smooth tracks, some full-range noise, some extremes
  function automatic logic signed [DATA_W-1:0] pick_coord(input int axis);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 65) begin
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0:       step[axis] = $signed($urandom_range(0, 32)) - 16;
          1:       step[axis] = $signed($urandom_range(0, 131072)) - 65536;
          default: step[axis] = $urandom;
        endcase
      end
      traj[axis] = traj[axis] + step[axis] + ($signed($urandom_range(0, 6)) - 3);
      return traj[axis];
    end
    if (mode < 85) return $urandom;
    case ($urandom_range(0, 4))
      0:       return MAXV;
      1:       return MINV;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  task automatic send_item(input logic signed [DATA_W-1:0] s,
                           input logic signed [DATA_W-1:0] d,
                           input bit typed, input est_t typed_want);
    est_t e;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid = 1'b1;
    pos_s    = s;
    pos_d    = d;
    do @(posedge clk); while (!in_ready);
    e = predict_estimate(s, d);
    expected_est[exp_tail] = typed ? typed_want : e;
    exp_tail = (exp_tail + 1) % EXP_DEPTH;
    exp_count++;
    burst_left--;
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] r);
    @(negedge clk);
    in_valid = 1'b0;
    while (exp_count != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = r;
    do @(posedge clk); while (!cfg_ready);
    rate_hz = r;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_result();
    est_t got;
    est_t want;
    got = '{vel_s, vel_d, acc_s, acc_d, vel_valid, acc_valid};
    results_seen++;
    if (exp_count == 0) begin
      if (mismatches < 10) $display("unexpected result vs=%0d vd=%0d as=%0d ad=%0d",
                                    got.vs, got.vd, got.as, got.ad);
      mismatches++;
      return;
    end
    want = expected_est[exp_head];
    exp_head = (exp_head + 1) % EXP_DEPTH;
    exp_count--;
    if (got.vs !== want.vs || got.vd !== want.vd || got.as !== want.as ||
        got.ad !== want.ad || got.vv !== want.vv || got.av !== want.av) begin
      if (mismatches < 10) begin
        $display("mismatch at result %0d", results_seen);
        $display("  got  vs=%0d vd=%0d as=%0d ad=%0d vv=%0b av=%0b",
                 got.vs, got.vd, got.as, got.ad, got.vv, got.av);
        $display("  want vs=%0d vd=%0d as=%0d ad=%0d vv=%0b av=%0b",
                 want.vs, want.vd, want.as, want.ad, want.vv, want.av);
      end
      mismatches++;
    end
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int  rx_cyc;
    int  rx_mode;
    int  hold_left;
    bit  held_off;
    out_ready = 1'b0;
    rx_cyc    = 0;
    rx_mode   = 0;
    hold_left = 0;
    held_off  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      @(negedge clk);
      rx_cyc++;
      if (rx_cyc % 48 == 0) rx_mode = $urandom_range(0, 3);
      if (!held_off && results_seen >= 300) begin
        held_off  = 1'b1;
        hold_left = 600;
      end
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          0, 1:    out_ready = 1'b1;
          2:       out_ready = $urandom_range(0, 1);
          default: out_ready = (rx_cyc % 5 == 0);
        endcase
      end
    end
  end

  initial begin
    logic [RATE_W-1:0] r;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    pos_s        = '0;
    pos_d        = '0;
    pos_fill     = 0;
    vel_fill     = 0;
    rate_hz      = RATE_RESET;
    exp_head     = 0;
    exp_tail     = 0;
    exp_count    = 0;
    mismatches   = 0;
    results_seen = 0;
    burst_left   = 0;
    traj         = '{0, 0};
    step         = '{3, -2};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_rate(dir_rows[i].rate);
      else send_item(dir_rows[i].s, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       r = 10'd1000;
        1:       r = 10'd1;
        2:       r = 10'd1023;
        3:       r = 10'd0;
        default: r = RATE_W'($urandom_range(1, 1000));
      endcase
      write_rate(r);
      for (int k = 0; k < 100; k++) send_item(pick_coord(0), pick_coord(1), 1'b0, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (exp_count != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_windowed_velocity_accel_estimator: clean");
    end else begin
      $display("tb_windowed_velocity_accel_estimator: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_windowed_velocity_accel_estimator: errors");
    $finish;
  end

endmodule
